// File: src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file of the block imports this package.
package wsd_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_MSG_END = 3'd1;
  localparam logic [2:0] KIND_PING    = 3'd2;
  localparam logic [2:0] KIND_PONG    = 3'd3;
  localparam logic [2:0] KIND_CLOSE   = 3'd4;
  localparam logic [2:0] KIND_ABORT   = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // Frame types.
  localparam logic [2:0] FT_TEXT   = 3'd0;
  localparam logic [2:0] FT_BINARY = 3'd1;
  localparam logic [2:0] FT_PING   = 3'd2;
  localparam logic [2:0] FT_PONG   = 3'd3;
  localparam logic [2:0] FT_CLOSE  = 3'd4;

  // Opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Connection states.
  localparam logic [1:0] LINK_OPEN    = 2'd0;
  localparam logic [1:0] LINK_CLOSING = 2'd1;
  localparam logic [1:0] LINK_CLOSED  = 2'd2;

  localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;
  localparam logic [20:0] MAX_LEN_RESET = 21'd1048576;
  localparam logic [6:0]  LEN_EXT16     = 7'd126;

  // Result queue between parser and output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  frame_type;
    logic [31:0] message_length;
    logic [15:0] close_code;
    logic [1:0]  conn_state;
  } res_t;

  // Up to two results pushed per accepted byte.
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] db, logic [2:0] ft,
                                  logic [31:0] len, logic [15:0] code);
    res_t r;
    r.kind           = kind;
    r.data_byte      = db;
    r.frame_type     = ft;
    r.message_length = len;
    r.close_code     = code;
    r.conn_state     = LINK_OPEN;
    return r;
  endfunction

  function automatic logic [2:0] type_of(logic [3:0] op, logic frag_bin);
    logic [2:0] t;
    unique case (op)
      OP_TEXT:  t = FT_TEXT;
      OP_BIN:   t = FT_BINARY;
      OP_PING:  t = FT_PING;
      OP_PONG:  t = FT_PONG;
      OP_CLOSE: t = FT_CLOSE;
      default:  t = frag_bin ? FT_BINARY : FT_TEXT;
    endcase
    return t;
  endfunction

endpackage

// File: src/wsd_parser.sv
// Front end: header parser, unmasking and fragment tracking, one byte per cycle while accept is high.
// Depends on wsd_pkg; feeds results to wsd_queue.
module wsd_parser import wsd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        chunk_end,
  input  logic [20:0] max_len,
  output push_t       push
);

  localparam int WX = (LEN_BITS > 32) ? LEN_BITS : 32;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_PAY  = 5'b10000
  } phase_t;

  phase_t              phase, phase_next;
  logic                fin, fin_next;
  logic [3:0]          opcode, opcode_next;
  logic                masked, masked_next;
  logic [2:0]          ext_cnt, ext_cnt_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic [LEN_BITS-1:0] frame_len, frame_len_next;
  logic [31:0]         mask_word, mask_word_next;
  logic [1:0]          mask_pos, mask_pos_next;
  logic [1:0]          pay_idx, pay_idx_next;
  logic                in_frag, in_frag_next;
  logic                frag_bin, frag_bin_next;
  logic [20:0]         frag_total, frag_total_next;
  logic                drop, drop_next;
  logic                discard, discard_next;
  logic [15:0]         close_code, close_code_next;
  logic [1:0]          link, link_next;

  always_comb begin
    logic [1:0]    nres;
    res_t          rs [2];
    logic          after_len;
    logic          do_begin;
    logic          do_end;
    logic [3:0]    op;
    logic [6:0]    l7;
    logic [7:0]    mbyte;
    logic [7:0]    d;
    logic [20:0]   tot;
    logic [WX-1:0] flw;
    logic [WX-1:0] limw;
    logic [WX-1:0] ftw;

    phase_next      = phase;
    fin_next        = fin;
    opcode_next     = opcode;
    masked_next     = masked;
    ext_cnt_next    = ext_cnt;
    remaining_next  = remaining;
    frame_len_next  = frame_len;
    mask_word_next  = mask_word;
    mask_pos_next   = mask_pos;
    pay_idx_next    = pay_idx;
    in_frag_next    = in_frag;
    frag_bin_next   = frag_bin;
    frag_total_next = frag_total;
    drop_next       = drop;
    discard_next    = discard;
    close_code_next = close_code;
    link_next       = link;
    nres            = 2'd0;
    rs[0]           = '0;
    rs[1]           = '0;
    after_len       = 1'b0;
    do_begin        = 1'b0;
    do_end          = 1'b0;
    op              = rx_byte[3:0];
    l7              = rx_byte[6:0];
    d               = '0;
    tot             = '0;
    flw             = '0;
    limw            = WX'(max_len);
    ftw             = WX'(frag_total);
    unique case (mask_pos)
      2'd0:    mbyte = mask_word[31:24];
      2'd1:    mbyte = mask_word[23:16];
      2'd2:    mbyte = mask_word[15:8];
      default: mbyte = mask_word[7:0];
    endcase

    if (accept) begin
      if (discard) begin
        if (chunk_end) begin
          discard_next = 1'b0;
        end
      end else begin
        unique case (phase)
          PH_HDR0: begin
            if ((rx_byte[6:4] != 3'd0) || (op >= 4'h3 && op <= 4'h7) || (op >= 4'hB)) begin
              rs[nres[0]] = mk_res(KIND_ERROR, 8'd0, FT_TEXT, 32'd0, 16'd0);
              nres = nres + 2'd1;
              discard_next = !chunk_end;
            end else begin
              fin_next    = rx_byte[7];
              opcode_next = op;
              if ((op == OP_TEXT || op == OP_BIN) && in_frag) begin
                rs[nres[0]] = mk_res(KIND_ABORT, 8'd0, frag_bin ? FT_BINARY : FT_TEXT,
                                     32'd0, 16'd0);
                nres = nres + 2'd1;
                in_frag_next    = 1'b0;
                frag_total_next = '0;
              end
              phase_next = PH_HDR1;
            end
          end
          PH_HDR1: begin
            masked_next    = rx_byte[7];
            remaining_next = '0;
            if (l7 >= LEN_EXT16) begin
              ext_cnt_next = (l7 == LEN_EXT16) ? 3'd1 : 3'd7;
              phase_next   = PH_EXT;
            end else begin
              remaining_next = LEN_BITS'(l7);
              after_len      = 1'b1;
            end
          end
          PH_EXT: begin
            // Saturate once the value can no longer take another byte.
            if (|remaining[LEN_BITS-1 -: 8]) begin
              remaining_next = '1;
            end else begin
              remaining_next = {remaining[LEN_BITS-9:0], rx_byte};
            end
            if (ext_cnt == 3'd0) begin
              after_len = 1'b1;
            end else begin
              ext_cnt_next = ext_cnt - 3'd1;
            end
          end
          PH_MASK: begin
            mask_word_next = {mask_word[23:0], rx_byte};
            mask_pos_next  = mask_pos + 2'd1;
            if (mask_pos == 2'd3) begin
              do_begin = 1'b1;
            end
          end
          PH_PAY: begin
            d             = rx_byte ^ mbyte;
            mask_pos_next = mask_pos + 2'd1;
            if (!drop) begin
              rs[nres[0]] = mk_res(KIND_PAYLOAD, d, type_of(opcode, frag_bin), 32'd0, 16'd0);
              nres = nres + 2'd1;
              if (opcode == OP_CLOSE) begin
                if (pay_idx == 2'd0) begin
                  close_code_next = {8'd0, d};
                end else if (pay_idx == 2'd1) begin
                  close_code_next = {close_code[7:0], d};
                end
              end
            end
            pay_idx_next   = (pay_idx == 2'd2) ? 2'd2 : pay_idx + 2'd1;
            remaining_next = remaining - LEN_BITS'(1);
            if (remaining == LEN_BITS'(1)) begin
              do_end = 1'b1;
            end
          end
          default: phase_next = PH_HDR0;
        endcase

        if (after_len) begin
          mask_word_next = '0;
          if (masked_next) begin
            phase_next    = PH_MASK;
            mask_pos_next = 2'd0;
          end else begin
            do_begin = 1'b1;
          end
        end

        if (do_begin) begin
          frame_len_next = remaining_next;
          flw            = WX'(remaining_next);
          drop_next      = 1'b0;
          mask_pos_next  = 2'd0;
          pay_idx_next   = 2'd0;
          if (opcode_next == OP_CONT) begin
            if (!in_frag_next || (ftw > limw) || (flw > limw - ftw)) begin
              drop_next = 1'b1;
            end
          end else if ((opcode_next == OP_TEXT || opcode_next == OP_BIN) && !fin_next) begin
            if (flw > limw) begin
              drop_next = 1'b1;
            end else begin
              in_frag_next    = 1'b1;
              frag_bin_next   = (opcode_next == OP_BIN);
              frag_total_next = '0;
            end
          end else if (opcode_next == OP_CLOSE) begin
            close_code_next = CLOSE_DEFAULT;
          end
          if (remaining_next == '0) begin
            do_end = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end

        if (do_end) begin
          phase_next = PH_HDR0;
          flw        = WX'(frame_len_next);
          if (!drop_next) begin
            unique case (opcode_next)
              OP_TEXT, OP_BIN: begin
                if (fin_next) begin
                  rs[nres[0]] = mk_res(KIND_MSG_END, 8'd0, type_of(opcode_next, frag_bin_next),
                                       flw[31:0], 16'd0);
                  nres = nres + 2'd1;
                end else begin
                  frag_total_next = flw[20:0];
                end
              end
              OP_CONT: begin
                tot             = frag_total_next + flw[20:0];
                frag_total_next = tot;
                if (fin_next) begin
                  rs[nres[0]] = mk_res(KIND_MSG_END, 8'd0,
                                       frag_bin_next ? FT_BINARY : FT_TEXT,
                                       32'(tot), 16'd0);
                  nres = nres + 2'd1;
                  in_frag_next    = 1'b0;
                  frag_total_next = '0;
                end
              end
              OP_PING: begin
                rs[nres[0]] = mk_res(KIND_PING, 8'd0, FT_PING, flw[31:0], 16'd0);
                nres = nres + 2'd1;
              end
              OP_PONG: begin
                rs[nres[0]] = mk_res(KIND_PONG, 8'd0, FT_PONG, flw[31:0], 16'd0);
                nres = nres + 2'd1;
              end
              OP_CLOSE: begin
                if (flw < WX'(2)) begin
                  close_code_next = CLOSE_DEFAULT;
                end
                link_next = (link == LINK_OPEN) ? LINK_CLOSING : LINK_CLOSED;
                rs[nres[0]] = mk_res(KIND_CLOSE, 8'd0, FT_CLOSE, flw[31:0], close_code_next);
                nres = nres + 2'd1;
              end
              default: ;
            endcase
          end
        end
      end
    end

    rs[0].conn_state = link_next;
    rs[1].conn_state = link_next;
    push.n = nres;
    push.a = rs[0];
    push.b = rs[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      fin        <= 1'b0;
      opcode     <= OP_CONT;
      masked     <= 1'b0;
      ext_cnt    <= '0;
      remaining  <= '0;
      frame_len  <= '0;
      mask_word  <= '0;
      mask_pos   <= '0;
      pay_idx    <= '0;
      in_frag    <= 1'b0;
      frag_bin   <= 1'b0;
      frag_total <= '0;
      drop       <= 1'b0;
      discard    <= 1'b0;
      close_code <= CLOSE_DEFAULT;
      link       <= LINK_OPEN;
    end else begin
      phase      <= phase_next;
      fin        <= fin_next;
      opcode     <= opcode_next;
      masked     <= masked_next;
      ext_cnt    <= ext_cnt_next;
      remaining  <= remaining_next;
      frame_len  <= frame_len_next;
      mask_word  <= mask_word_next;
      mask_pos   <= mask_pos_next;
      pay_idx    <= pay_idx_next;
      in_frag    <= in_frag_next;
      frag_bin   <= frag_bin_next;
      frag_total <= frag_total_next;
      drop       <= drop_next;
      discard    <= discard_next;
      close_code <= close_code_next;
      link       <= link_next;
    end
  end

endmodule

// File: src/wsd_queue.sv
// Short result queue between the parser and the output stage.
// Depends on wsd_pkg; takes up to two results per cycle, gives one.
module wsd_queue import wsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output logic  room2,
  output logic  not_empty,
  output res_t  head
);

  res_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   count;
  logic [Q_AW-1:0] wp1;

  assign wp1       = wp + Q_AW'(1);
  assign room2     = (count <= (Q_AW+1)'(Q_DEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (push.n != 2'd0 && wp == Q_AW'(i)) begin
        mem[i] <= push.a;
      end
      if (push.n == 2'd2 && wp1 == Q_AW'(i)) begin
        mem[i] <= push.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + Q_AW'(push.n);
      rp    <= rp + Q_AW'(pop);
      count <= count + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);
    end
  end

endmodule

// File: src/wsd_out.sv
// Back end: output register that drains the result queue onto the result channel.
// Depends on wsd_pkg.
module wsd_out import wsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  res_t q_head,
  output logic q_pop,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_res
);

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= q_head;
    end
  end

endmodule

// File: src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer (receive side).
// Depends on wsd_pkg, wsd_parser, wsd_queue and wsd_out.
//
// Usage: received stream bytes enter on the input channel (in_valid, in_stall,
// rx_byte, chunk_end); one transaction moves one byte. The parser decodes the
// frame header, unmasks payload and tracks fragmented messages in the cycle the
// byte is taken, and writes zero, one or two result items into a four-entry
// queue. An output register drains the queue onto the result channel
// (out_valid, out_stall and the result fields), one transaction per cycle while
// out_stall is low. A result is written into the queue at the edge that accepts
// its byte and passes from there through the output register. Throughput: one
// byte per cycle while out_stall is low and each byte yields at most one result;
// a byte that yields two results (a last payload byte plus its frame event)
// takes an extra output transaction, absorbed by the queue. in_stall rises when
// the queue has fewer than two free entries, so a stalled receiver backs up into
// the input channel after the queue fills.
// Reset (rst, synchronous) empties the queue, returns the parser to the first header
// byte, sets the link open and max_len to 1048576. The user must write the limit
// register through cfg_wr_en and cfg_wr_data only while the block is idle; the block does not enforce it.
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  frame_type,
  output logic [31:0] message_length,
  output logic [15:0] close_code,
  output logic [1:0]  conn_state,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data
);

  logic [20:0] max_len;
  logic        accept;
  logic        room2;
  logic        q_valid;
  logic        q_pop;
  res_t        q_head;
  res_t        out_res;
  push_t       push;

  // Limit register for fragmented messages.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // A byte is taken only when the queue can hold both results it may cause.
  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  wsd_parser #(.LEN_BITS(LEN_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .chunk_end (chunk_end),
    .max_len   (max_len),
    .push      (push)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (q_pop),
    .room2     (room2),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wsd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind           = out_res.kind;
  assign data_byte      = out_res.data_byte;
  assign frame_type     = out_res.frame_type;
  assign message_length = out_res.message_length;
  assign close_code     = out_res.close_code;
  assign conn_state     = out_res.conn_state;

endmodule

// File: src/wsd_checker.sv
// Port-level checker for the WebSocket frame deframer, with its bind.
// Depends on wsd_pkg; attaches to websocket_frame_deframer.
module wsd_checker import wsd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [7:0]  data_byte,
  input logic [15:0] close_code,
  input logic [1:0]  conn_state
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("stalled result changed");

  // Only payload results carry a data byte.
  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0)
    else $error("data byte on a non-payload result");

  // Only close events carry a close code, and a close never leaves the link open.
  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CLOSE |-> close_code == 16'd0)
    else $error("close code on a non-close result");

  a_close_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CLOSE |-> conn_state == LINK_CLOSING || conn_state == LINK_CLOSED)
    else $error("close event with link open");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .data_byte  (data_byte),
  .close_code (close_code),
  .conn_state (conn_state)
);
